[design/rtf_pkg.sv]
// ----------------------------------------------------------------------------
// rtf_pkg
// Shared types, phase codes and helper functions of the roundabout tracker.
// ----------------------------------------------------------------------------
package rtf_pkg;

  localparam int LEN_W   = 8;
  localparam int CNT_W   = 8;
  localparam int PHASE_W = 4;
  localparam int CFG_IDX_W = 3;
  localparam int MAX_POINTS = 255;

  localparam logic [PHASE_W-1:0] PH_NONE    = 4'd0;
  localparam logic [PHASE_W-1:0] PH_L_BEGIN = 4'd1;
  localparam logic [PHASE_W-1:0] PH_L_IN    = 4'd2;
  localparam logic [PHASE_W-1:0] PH_L_RUN   = 4'd3;
  localparam logic [PHASE_W-1:0] PH_L_OUT   = 4'd4;
  localparam logic [PHASE_W-1:0] PH_L_END   = 4'd5;
  localparam logic [PHASE_W-1:0] PH_R_BEGIN = 4'd6;
  localparam logic [PHASE_W-1:0] PH_R_IN    = 4'd7;
  localparam logic [PHASE_W-1:0] PH_R_RUN   = 4'd8;
  localparam logic [PHASE_W-1:0] PH_R_OUT   = 4'd9;
  localparam logic [PHASE_W-1:0] PH_R_END   = 4'd10;

  localparam logic [CFG_IDX_W-1:0] CFG_LOSE_PTS_BEGIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOSE_PTS        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REGAIN_PTS      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EXIT_REGAIN_PTS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CORNER_NEAR_PTS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LIMIT     = 3'd5;

  typedef struct packed {
    logic [LEN_W-1:0] lose_pts_begin;
    logic [LEN_W-1:0] lose_pts;
    logic [LEN_W-1:0] regain_pts;
    logic [LEN_W-1:0] exit_regain_pts;
    logic [LEN_W-1:0] corner_near_pts;
    logic [CNT_W-1:0] frame_limit;
  } cfg_t;

  typedef struct packed {
    logic [LEN_W-1:0] left_len;
    logic [LEN_W-1:0] right_len;
    logic             left_corner_found;
    logic             right_corner_found;
    logic [LEN_W-1:0] left_corner_index;
    logic [LEN_W-1:0] right_corner_index;
    logic             left_straight;
    logic             right_straight;
  } feat_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [CNT_W-1:0]   left_lost;
    logic [CNT_W-1:0]   right_lost;
    logic [CNT_W-1:0]   left_found;
    logic [CNT_W-1:0]   right_found;
    logic               follow;
  } trk_state_t;

  typedef struct packed {
    logic               follow_right;
    logic [PHASE_W-1:0] phase_out;
    logic               active;
    logic [LEN_W-1:0]   left_len_out;
    logic [LEN_W-1:0]   right_len_out;
  } res_t;

  typedef struct packed {
    logic [CNT_W-1:0] lost;
    logic [CNT_W-1:0] found;
    logic             advance;
  } lr_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
  endfunction

  function automatic logic [LEN_W-1:0] clamp_pts(input logic [LEN_W-1:0] v);
    return (int'(v) > MAX_POINTS) ? LEN_W'(MAX_POINTS) : v;
  endfunction

  function automatic lr_t lose_regain(input logic [LEN_W-1:0] len,
                                      input logic [LEN_W-1:0] lose_thr,
                                      input logic [LEN_W-1:0] regain,
                                      input logic [CNT_W-1:0] limit,
                                      input logic [CNT_W-1:0] lost,
                                      input logic [CNT_W-1:0] found);
    lr_t r;
    r.lost    = (len < lose_thr) ? sat_inc(lost) : lost;
    r.found   = found;
    r.advance = 1'b0;
    if ((len > regain) && (r.lost > limit)) begin
      r.found = sat_inc(found);
      if (r.found > limit) begin
        r.advance = 1'b1;
        r.lost    = '0;
        r.found   = '0;
      end
    end
    return r;
  endfunction

endpackage

[design/rtf_cfg_regs.sv]
// ----------------------------------------------------------------------------
// rtf_cfg_regs
// Threshold register file written through the configuration channel.
// ----------------------------------------------------------------------------
module rtf_cfg_regs import rtf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_idx,
  input  logic [LEN_W-1:0]     wr_data,
  output cfg_t                 cfg
);

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_idx)
        CFG_LOSE_PTS_BEGIN:  cfg_nxt.lose_pts_begin  = wr_data;
        CFG_LOSE_PTS:        cfg_nxt.lose_pts        = wr_data;
        CFG_REGAIN_PTS:      cfg_nxt.regain_pts      = wr_data;
        CFG_EXIT_REGAIN_PTS: cfg_nxt.exit_regain_pts = wr_data;
        CFG_CORNER_NEAR_PTS: cfg_nxt.corner_near_pts = wr_data;
        CFG_FRAME_LIMIT:     cfg_nxt.frame_limit     = wr_data;
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lose_pts_begin  <= 8'd15;
      cfg_r.lose_pts        <= 8'd10;
      cfg_r.regain_pts      <= 8'd25;
      cfg_r.exit_regain_pts <= 8'd35;
      cfg_r.corner_near_pts <= 8'd25;
      cfg_r.frame_limit     <= 8'd3;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[design/rtf_phase_logic.sv]
// ----------------------------------------------------------------------------
// rtf_phase_logic
// Detection and phase rule for one frame: next tracker state and result word.
// ----------------------------------------------------------------------------
module rtf_phase_logic import rtf_pkg::*; (
  input  feat_t      feat,
  input  trk_state_t st,
  input  cfg_t       cfg,
  output trk_state_t st_nxt,
  output res_t       res
);

  logic [LEN_W-1:0] llen, rlen;
  lr_t              lr;

  assign llen = clamp_pts(feat.left_len);
  assign rlen = clamp_pts(feat.right_len);

  always_comb begin
    st_nxt            = st;
    res.active        = 1'b0;
    res.left_len_out  = llen;
    res.right_len_out = rlen;
    lr                = '0;

    if (st.phase == PH_NONE && feat.left_corner_found && !feat.right_corner_found &&
        feat.right_straight) begin
      st_nxt.phase       = PH_L_BEGIN;
      st_nxt.left_lost   = '0;
      st_nxt.right_lost  = '0;
      st_nxt.left_found  = '0;
      st_nxt.right_found = '0;
    end else if (st.phase == PH_NONE && !feat.left_corner_found &&
                 feat.right_corner_found && feat.left_straight) begin
      st_nxt.phase       = PH_R_BEGIN;
      st_nxt.left_lost   = '0;
      st_nxt.right_lost  = '0;
      st_nxt.left_found  = '0;
      st_nxt.right_found = '0;
    end

    unique case (st_nxt.phase)
      PH_L_BEGIN: begin
        res.active    = 1'b1;
        st_nxt.follow = 1'b1;
        lr = lose_regain(llen, cfg.lose_pts_begin, cfg.regain_pts, cfg.frame_limit,
                         st_nxt.left_lost, st_nxt.left_found);
        st_nxt.left_lost  = lr.lost;
        st_nxt.left_found = lr.found;
        if (lr.advance) st_nxt.phase = PH_L_IN;
      end
      PH_L_IN: begin
        res.active    = 1'b1;
        st_nxt.follow = 1'b0;
        lr = lose_regain(rlen, cfg.lose_pts, cfg.regain_pts, cfg.frame_limit,
                         st_nxt.right_lost, st_nxt.right_found);
        st_nxt.right_lost  = lr.lost;
        st_nxt.right_found = lr.found;
        if (lr.advance) st_nxt.phase = PH_L_RUN;
      end
      PH_L_RUN: begin
        res.active    = 1'b1;
        st_nxt.follow = 1'b0;
        if (feat.right_corner_found) begin
          res.right_len_out = clamp_pts(feat.right_corner_index);
          if (feat.right_corner_index < cfg.corner_near_pts) st_nxt.phase = PH_L_OUT;
        end
      end
      PH_L_OUT: begin
        res.active    = 1'b1;
        st_nxt.follow = 1'b0;
        if (feat.right_straight && !feat.right_corner_found) st_nxt.phase = PH_L_END;
      end
      PH_L_END: begin
        res.active    = 1'b1;
        st_nxt.follow = 1'b1;
        if (llen < cfg.lose_pts) st_nxt.left_lost = sat_inc(st_nxt.left_lost);
        if (llen > cfg.exit_regain_pts && st_nxt.left_lost > cfg.frame_limit) begin
          st_nxt.phase       = PH_NONE;
          st_nxt.left_lost   = '0;
          st_nxt.right_lost  = '0;
          st_nxt.left_found  = '0;
          st_nxt.right_found = '0;
        end
      end
      PH_R_BEGIN: begin
        res.active    = 1'b1;
        st_nxt.follow = 1'b0;
        lr = lose_regain(rlen, cfg.lose_pts, cfg.regain_pts, cfg.frame_limit,
                         st_nxt.right_lost, st_nxt.right_found);
        st_nxt.right_lost  = lr.lost;
        st_nxt.right_found = lr.found;
        if (lr.advance) st_nxt.phase = PH_R_IN;
      end
      PH_R_IN: begin
        res.active    = 1'b1;
        st_nxt.follow = 1'b1;
        lr = lose_regain(llen, cfg.lose_pts, cfg.regain_pts, cfg.frame_limit,
                         st_nxt.left_lost, st_nxt.left_found);
        st_nxt.left_lost  = lr.lost;
        st_nxt.left_found = lr.found;
        if (lr.advance) st_nxt.phase = PH_R_RUN;
      end
      PH_R_RUN: begin
        res.active    = 1'b1;
        st_nxt.follow = 1'b0;
        if (feat.left_corner_found) begin
          res.left_len_out = clamp_pts(feat.left_corner_index);
          if (feat.left_corner_index < cfg.corner_near_pts) st_nxt.phase = PH_R_OUT;
        end
      end
      PH_R_OUT: begin
        res.active    = 1'b1;
        st_nxt.follow = 1'b1;
        if (feat.left_straight && !feat.left_corner_found) st_nxt.phase = PH_R_END;
      end
      PH_R_END: begin
        res.active    = 1'b1;
        st_nxt.follow = 1'b0;
        if (rlen < cfg.lose_pts) st_nxt.right_lost = sat_inc(st_nxt.right_lost);
        if (rlen > cfg.exit_regain_pts && st_nxt.right_lost > cfg.frame_limit) begin
          st_nxt.phase       = PH_NONE;
          st_nxt.left_lost   = '0;
          st_nxt.right_lost  = '0;
          st_nxt.left_found  = '0;
          st_nxt.right_found = '0;
        end
      end
      default: begin
        res.active = 1'b0;
      end
    endcase

    res.follow_right = st_nxt.follow;
    res.phase_out    = st_nxt.phase;
  end

endmodule

[design/roundabout_track_fsm_unit.sv]
// ----------------------------------------------------------------------------
// roundabout_track_fsm_unit
// Roundabout phase tracker: one frame word in, one result word out.
// ----------------------------------------------------------------------------
// Pipeline: input register, then phase logic into the result register.
// Throughput: 1 word per cycle while out_ready is high or the result register
//   is empty; the phase and counter registers update once per word.
// Reset: synchronous, active low; phase idle, counters zero, follow left,
//   thresholds at their defaults, both pipeline stages empty.
// ----------------------------------------------------------------------------
module roundabout_track_fsm_unit import rtf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [LEN_W-1:0]     in_left_len,
  input  logic [LEN_W-1:0]     in_right_len,
  input  logic                 in_left_corner_found,
  input  logic                 in_right_corner_found,
  input  logic [LEN_W-1:0]     in_left_corner_index,
  input  logic [LEN_W-1:0]     in_right_corner_index,
  input  logic                 in_left_straight,
  input  logic                 in_right_straight,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_follow_right,
  output logic [PHASE_W-1:0]   out_phase_out,
  output logic                 out_active,
  output logic [LEN_W-1:0]     out_left_len_out,
  output logic [LEN_W-1:0]     out_right_len_out,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LEN_W-1:0]     cfg_data
);

  cfg_t       cfg;
  feat_t      feat_r, feat_nxt;
  logic       s1_valid_r, s1_valid_nxt;
  trk_state_t st_r, st_nxt;
  res_t       res, res_r;
  logic       out_valid_r, out_valid_nxt;
  logic       advance;
  logic       in_fire;

  assign cfg_ready = 1'b1;

  rtf_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid && cfg_ready),
    .wr_idx  (cfg_index),
    .wr_data (cfg_data),
    .cfg     (cfg)
  );

  rtf_phase_logic u_phase (
    .feat   (feat_r),
    .st     (st_r),
    .cfg    (cfg),
    .st_nxt (st_nxt),
    .res    (res)
  );

  // advance the input stage into the result register when it is empty or its word is taken
  assign advance  = !out_valid_r || out_ready;
  assign in_ready = advance || !s1_valid_r;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    feat_nxt     = feat_r;
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      feat_nxt.left_len           = in_left_len;
      feat_nxt.right_len          = in_right_len;
      feat_nxt.left_corner_found  = in_left_corner_found;
      feat_nxt.right_corner_found = in_right_corner_found;
      feat_nxt.left_corner_index  = in_left_corner_index;
      feat_nxt.right_corner_index = in_right_corner_index;
      feat_nxt.left_straight      = in_left_straight;
      feat_nxt.right_straight     = in_right_straight;
      s1_valid_nxt                = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = advance ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_valid_r && advance) st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    feat_r <= feat_nxt;
    if (s1_valid_r && advance) res_r <= res;
  end

  assign out_valid         = out_valid_r;
  assign out_follow_right  = res_r.follow_right;
  assign out_phase_out     = res_r.phase_out;
  assign out_active        = res_r.active;
  assign out_left_len_out  = res_r.left_len_out;
  assign out_right_len_out = res_r.right_len_out;

`ifndef SYNTHESIS
  a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.phase <= PH_R_END)
    else $error("phase register holds an unused code");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_fire && s1_valid_r && out_valid_r && !out_ready))
    else $error("input word taken while both stages are stalled");

  a_entry_active: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && advance && st_r.phase == PH_NONE && st_nxt.phase != PH_NONE)
      |=> out_active)
    else $error("roundabout entry without active result");

  a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> $stable(st_r))
    else $error("tracker state moved while result stalled");
`endif

endmodule
